// ----- hdl/lzwd_pkg.sv -----
// shared types and constants for the lz77 window decompressor
`timescale 1ns / 1ps

package lzwd_pkg;

    // history window
    localparam int WINDOW_DEPTH = 4096;
    localparam int WINDOW_AW    = $clog2(WINDOW_DEPTH);
    localparam int PC_W         = WINDOW_AW + 1;

    // stream format
    localparam int REM_W     = 24;
    localparam int LEN_W     = 5;
    localparam int MIN_MATCH = 3;
    localparam logic [7:0] FLAG_TOP = 8'h80;

    // command queue between parser and copy engine
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // parser phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_FLAGS,
        PH_DATA,
        PH_TOKEN_LOW,
        PH_DONE
    } t_phase;

    // copy engine states
    typedef enum logic [1:0] {
        ES_IDLE,
        ES_READ,
        ES_OUT
    } t_eng_state;

    // one classified item: a literal or a back-reference
    typedef struct packed {
        logic                    is_copy;
        logic                    fresh;   // first command of a new stream
        logic                    done;    // command ends the declared size
        logic [7:0]              lit;
        logic [LEN_W-1:0]        len;
        logic [PC_W-1:0]         ref_dist;
    } t_cmd;

    // queue status towards both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- hdl/lzwd_ram.sv -----
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps

module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/lzwd_parser.sv -----
// front end: parses header, flag bytes and tokens into commands
`timescale 1ns / 1ps

module lzwd_parser import lzwd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  logic [7:0] i_byte,
    input  logic      i_start,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_cmd      o_cmd
);

    t_phase           r_phase, n_phase;
    logic [1:0]       r_hdr_idx, n_hdr_idx;
    logic [REM_W-1:0] r_remaining, n_remaining;
    logic [7:0]       r_flags, n_flags;
    logic [2:0]       r_bit_idx, n_bit_idx;
    logic [7:0]       r_token_high, n_token_high;
    logic             r_fresh, n_fresh;

    logic             accept;
    logic [LEN_W-1:0] raw_len;
    logic [LEN_W-1:0] clip_len;
    logic [REM_W-1:0] rem_after;
    logic [REM_W-1:0] rem_hdr;

    // one beat is taken whenever the queue has room
    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;

    // token length, clipped to what is left of the stream
    assign raw_len  = LEN_W'(r_token_high[7:4]) + LEN_W'(MIN_MATCH);
    assign clip_len = (r_remaining < REM_W'(raw_len)) ? r_remaining[LEN_W-1:0] : raw_len;

    // next state and command
    always_comb begin
        n_phase      = r_phase;
        n_hdr_idx    = r_hdr_idx;
        n_remaining  = r_remaining;
        n_flags      = r_flags;
        n_bit_idx    = r_bit_idx;
        n_token_high = r_token_high;
        n_fresh      = r_fresh;
        o_push       = 1'b0;
        o_cmd        = '0;
        rem_after    = r_remaining;
        rem_hdr      = r_remaining;

        if (accept) begin
            if (i_start) begin
                n_phase      = PH_HEADER;
                n_hdr_idx    = 2'd1;
                n_remaining  = '0;
                n_flags      = '0;
                n_bit_idx    = '0;
                n_token_high = '0;
                n_fresh      = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        // size bytes arrive low byte first after the type byte
                        unique case (r_hdr_idx)
                            2'd1:    rem_hdr = {r_remaining[23:8], i_byte};
                            2'd2:    rem_hdr = {r_remaining[23:16], i_byte, r_remaining[7:0]};
                            2'd3:    rem_hdr = {i_byte, r_remaining[15:0]};
                            default: rem_hdr = r_remaining;
                        endcase
                        n_remaining = rem_hdr;
                        if (r_hdr_idx == 2'd3) begin
                            n_hdr_idx = '0;
                            n_phase   = (rem_hdr == '0) ? PH_DONE : PH_FLAGS;
                        end else begin
                            n_hdr_idx = r_hdr_idx + 2'd1;
                        end
                    end
                    PH_FLAGS: begin
                        n_flags   = i_byte;
                        n_bit_idx = '0;
                        n_phase   = PH_DATA;
                    end
                    PH_DATA: begin
                        if ((r_flags & (FLAG_TOP >> r_bit_idx)) != '0) begin
                            n_token_high = i_byte;
                            n_phase      = PH_TOKEN_LOW;
                        end else begin
                            rem_after      = r_remaining - REM_W'(1);
                            o_push         = 1'b1;
                            o_cmd.is_copy  = 1'b0;
                            o_cmd.fresh    = r_fresh;
                            o_cmd.done     = (rem_after == '0);
                            o_cmd.lit      = i_byte;
                            o_cmd.len      = LEN_W'(1);
                            o_cmd.ref_dist = '0;
                        end
                    end
                    PH_TOKEN_LOW: begin
                        rem_after      = r_remaining - REM_W'(clip_len);
                        o_push         = 1'b1;
                        o_cmd.is_copy  = 1'b1;
                        o_cmd.fresh    = r_fresh;
                        o_cmd.done     = (rem_after == '0);
                        o_cmd.lit      = i_byte;
                        o_cmd.len      = clip_len;
                        o_cmd.ref_dist = {1'b0, r_token_high[3:0], i_byte} + PC_W'(1);
                    end
                    PH_IDLE, PH_DONE: begin
                        // bytes outside a stream are dropped
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase

                // step to the next flag bit after a finished item
                if (o_push) begin
                    n_remaining = rem_after;
                    n_bit_idx   = r_bit_idx + 3'd1;
                    n_fresh     = 1'b0;
                    if (rem_after == '0) begin
                        n_phase = PH_DONE;
                    end else if (r_bit_idx == 3'd7) begin
                        n_phase = PH_FLAGS;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
        end
    end

    // parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_hdr_idx    <= '0;
            r_remaining  <= '0;
            r_flags      <= '0;
            r_bit_idx    <= '0;
            r_token_high <= '0;
            r_fresh      <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_idx    <= n_hdr_idx;
            r_remaining  <= n_remaining;
            r_flags      <= n_flags;
            r_bit_idx    <= n_bit_idx;
            r_token_high <= n_token_high;
            r_fresh      <= n_fresh;
        end
    end

endmodule

// ----- hdl/lzwd_cmd_queue.sv -----
// short command fifo between the parser and the copy engine
`timescale 1ns / 1ps

module lzwd_cmd_queue import lzwd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    t_cmd                r_slots [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_status.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_cmd          = r_slots[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

endmodule

// ----- hdl/lzwd_copy_engine.sv -----
// back end: writes literals and replays back-references from the history
`timescale 1ns / 1ps

module lzwd_copy_engine import lzwd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_status  i_q_status,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic       o_done,
    output logic       o_bad
);

    t_eng_state           r_state, n_state;
    logic [WINDOW_AW-1:0] r_wp, n_wp;
    logic [PC_W-1:0]      r_pc, n_pc;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [PC_W-1:0]      r_dist, n_dist;
    logic                 r_cmd_done, n_cmd_done;
    logic                 r_bad, n_bad;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_byte, n_out_byte;
    logic                 r_out_last, n_out_last;
    logic                 r_out_done, n_out_done;
    logic                 r_out_bad, n_out_bad;

    logic                 out_free;
    logic [WINDOW_AW-1:0] wp_eff;
    logic [PC_W-1:0]      pc_eff;
    logic [PC_W-1:0]      pc_inc;
    logic                 ram_we;
    logic [WINDOW_AW-1:0] ram_waddr;
    logic [7:0]           ram_wdata;
    logic                 ram_re;
    logic [WINDOW_AW-1:0] ram_raddr;
    logic [7:0]           ram_rdata;
    logic [7:0]           copy_byte;

    // history window
    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // output register can take a beat when empty or being drained
    assign out_free = !r_out_valid || i_ready;

    // a new stream restarts position and produced count
    assign wp_eff = i_cmd.fresh ? '0 : r_wp;
    assign pc_eff = i_cmd.fresh ? '0 : r_pc;

    // saturating produced count for the byte being written
    always_comb begin
        logic [PC_W-1:0] base;
        base   = (r_state == ES_IDLE) ? pc_eff : r_pc;
        pc_inc = (base < PC_W'(WINDOW_DEPTH)) ? base + PC_W'(1) : base;
    end

    assign copy_byte = r_bad ? 8'd0 : ram_rdata;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_pc        = r_pc;
        n_len       = r_len;
        n_dist      = r_dist;
        n_cmd_done  = r_cmd_done;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !i_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;
        n_out_bad   = r_out_bad;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_wp;
        ram_wdata   = copy_byte;
        ram_re      = 1'b0;
        ram_raddr   = r_wp - r_dist[WINDOW_AW-1:0];

        unique case (r_state)
            ES_IDLE: begin
                if (!i_q_status.empty && out_free) begin
                    o_pop = 1'b1;
                    if (i_cmd.is_copy) begin
                        n_wp       = wp_eff;
                        n_pc       = pc_eff;
                        n_len      = i_cmd.len;
                        n_dist     = i_cmd.ref_dist;
                        n_cmd_done = i_cmd.done;
                        n_state    = ES_READ;
                    end else begin
                        // literal goes straight to history and output
                        ram_we      = 1'b1;
                        ram_waddr   = wp_eff;
                        ram_wdata   = i_cmd.lit;
                        n_wp        = wp_eff + WINDOW_AW'(1);
                        n_pc        = pc_inc;
                        n_out_valid = 1'b1;
                        n_out_byte  = i_cmd.lit;
                        n_out_last  = 1'b1;
                        n_out_done  = i_cmd.done;
                        n_out_bad   = 1'b0;
                    end
                end
            end
            ES_READ: begin
                // fetch the source byte; a reference before the start reads as zero
                ram_re  = 1'b1;
                n_bad   = (r_dist > r_pc);
                n_state = ES_OUT;
            end
            ES_OUT: begin
                if (out_free) begin
                    ram_we      = 1'b1;
                    n_wp        = r_wp + WINDOW_AW'(1);
                    n_pc        = pc_inc;
                    n_len       = r_len - LEN_W'(1);
                    n_out_valid = 1'b1;
                    n_out_byte  = copy_byte;
                    n_out_last  = (r_len == LEN_W'(1));
                    n_out_done  = r_cmd_done && (r_len == LEN_W'(1));
                    n_out_bad   = r_bad;
                    n_state     = (r_len == LEN_W'(1)) ? ES_IDLE : ES_READ;
                end
            end
            default: begin
                n_state = ES_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ES_IDLE;
            r_wp        <= '0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_dist     <= n_dist;
        r_cmd_done <= n_cmd_done;
        r_bad      <= n_bad;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
        r_out_bad  <= n_out_bad;
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;
    assign o_done  = r_out_done;
    assign o_bad   = r_out_bad;

endmodule

// ----- hdl/lz77_window_decompressor_top.sv -----
// top level of the lz77 window decompressor
`timescale 1ns / 1ps

// Decompresses a type-10 LZ77 stream with a 4 KiB window, one compressed byte per input
// beat. The parser takes a beat whenever its four-entry command queue has room; header,
// flag and first token bytes produce nothing. A literal is popped from the head of the
// queue and written to the history and the output register together, so literals stream
// at one byte per cycle while the output is not stalled. For a back-reference of length
// n (3 to 18, clipped at the end of the stream) the copy engine takes the command from
// the queue, then for each copied byte reads and then writes the history RAM, since a
// byte may depend on the one written just before; an output stall holds the write.
// Sustained input rate is set by the copy engine. The history is not cleared after
// reset and needs no clearing pass; bytes from before the stream start read as zero
// with tuser bit 1 set. A beat with tuser set starts a new stream.

module lz77_window_decompressor_top import lzwd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [0:0] s_tuser,   // [0] stream_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic [1:0] m_tuser    // [0] stream_done, [1] bad_reference
);

    t_q_status q_status;
    logic      q_push;
    logic      q_pop;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    logic      out_done;
    logic      out_bad;

    // front: parse and classify
    lzwd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_tvalid),
        .o_ready    (s_tready),
        .i_byte     (s_tdata),
        .i_start    (s_tuser[0]),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    // command queue
    lzwd_cmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_cmd    (push_cmd),
        .i_pop    (q_pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    // back: execute commands against the history
    lzwd_copy_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_cmd      (head_cmd),
        .o_pop      (q_pop),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_byte     (m_tdata),
        .o_last     (m_tlast),
        .o_done     (out_done),
        .o_bad      (out_bad)
    );

    assign m_tuser = {out_bad, out_done};

    // a command is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_status.full))
        else $error("command pushed into full queue");

    // a bad reference always delivers a zero byte
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == 8'd0))
        else $error("bad reference with nonzero data");

    // the end of the stream closes a run
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("stream done without last");

    // popping only happens with something in the queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule

// ----- tb/lz77_window_decompressor_top_tb.sv -----
// self-checking testbench for the lz77 window decompressor top level
`timescale 1ns / 1ps

module lz77_window_decompressor_top_tb import lzwd_pkg::*; ();

    // one output beat as the decompressor should present it
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
        logic       bad;
    } t_out_beat;

    // tracks the decompressor state and the output bytes it owes
    class lz_output_tracker;
        logic [7:0]          window [WINDOW_DEPTH];
        logic [WINDOW_AW-1:0] wr_pos   = '0;
        logic [PC_W-1:0]     produced = '0;
        logic [REM_W-1:0]    remaining = '0;
        t_phase              phase    = PH_IDLE;
        logic [1:0]          hdr_idx  = '0;
        logic [7:0]          flags    = '0;
        logic [2:0]          bit_idx  = '0;
        logic [7:0]          tok_hi   = '0;
        t_out_beat           expected_bytes [$];
        int unsigned         mismatches = 0;

        function int outstanding();
            return expected_bytes.size();
        endfunction

        // write one byte into the window and queue the beat it should cause
        function void put_byte(logic [7:0] value, logic bad, logic last);
            t_out_beat beat;
            window[wr_pos] = value;
            wr_pos = wr_pos + 1'b1;
            if (produced < WINDOW_DEPTH) begin
                produced = produced + 1'b1;
            end
            remaining = remaining - 1'b1;
            beat.data = value;
            beat.last = last;
            beat.done = (remaining == 0);
            beat.bad  = bad;
            expected_bytes.push_back(beat);
        endfunction

        // step to the next flag bit, the next flag byte or the end of the stream
        function void next_item();
            if (remaining == 0) begin
                phase = PH_DONE;
            end else if (bit_idx == 3'd7) begin
                phase = PH_FLAGS;
            end else begin
                phase = PH_DATA;
            end
            bit_idx = bit_idx + 1'b1;
        endfunction

        // one accepted input beat
        function void absorb_input(logic [7:0] b, logic st);
            logic [LEN_W-1:0]     len;
            logic [PC_W-1:0]      ref_dist;
            logic [WINDOW_AW-1:0] rd_idx;
            int                   k;
            if (st) begin
                phase     = PH_HEADER;
                hdr_idx   = 2'd1;
                remaining = '0;
                wr_pos    = '0;
                produced  = '0;
                flags     = '0;
                bit_idx   = '0;
                tok_hi    = '0;
                return;
            end
            case (phase)
                PH_HEADER: begin
                    remaining = remaining | (REM_W'(b) << (8 * (hdr_idx - 1)));
                    if (hdr_idx == 2'd3) begin
                        hdr_idx = '0;
                        phase   = (remaining == 0) ? PH_DONE : PH_FLAGS;
                    end else begin
                        hdr_idx = hdr_idx + 1'b1;
                    end
                end
                PH_FLAGS: begin
                    flags   = b;
                    bit_idx = '0;
                    phase   = PH_DATA;
                end
                PH_DATA: begin
                    if ((flags & (FLAG_TOP >> bit_idx)) != 0) begin
                        tok_hi = b;
                        phase  = PH_TOKEN_LOW;
                    end else begin
                        put_byte(b, 1'b0, 1'b1);
                        next_item();
                    end
                end
                PH_TOKEN_LOW: begin
                    len      = LEN_W'(tok_hi[7:4] + MIN_MATCH);
                    ref_dist = PC_W'({tok_hi[3:0], b}) + 1'b1;
                    // last token of the stream is cut to what is left
                    if (len > remaining) begin
                        len = LEN_W'(remaining);
                    end
                    for (k = 0; k < len; k++) begin
                        // reaching before the stream start gives a flagged zero
                        if (ref_dist > produced) begin
                            put_byte(8'h00, 1'b1, k == len - 1);
                        end else begin
                            rd_idx = wr_pos - ref_dist[WINDOW_AW-1:0];
                            put_byte(window[rd_idx], 1'b0, k == len - 1);
                        end
                    end
                    next_item();
                end
                default: begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        // one accepted output beat against the oldest owed byte
        function void match_output(logic [7:0] data, logic last, logic done, logic bad);
            t_out_beat want;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected output beat, expected none, actual %0h", $time, data);
                return;
            end
            want = expected_bytes.pop_front();
            compare_field("out_byte", want.data, data);
            compare_field("last_of_run", 8'(want.last), 8'(last));
            compare_field("stream_done", 8'(want.done), 8'(done));
            compare_field("bad_reference", 8'(want.bad), 8'(bad));
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;   // [7:0] in_byte
    logic [0:0] s_tuser   = 1'b0;    // [0] stream_start
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;             // [7:0] out_byte
    logic       m_tlast;
    logic [1:0] m_tuser;             // [0] stream_done, [1] bad_reference

    lz_output_tracker tracker = new();
    bit               no_idle    = 1'b0;
    int unsigned      stim_items = 0;

    lz77_window_decompressor_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // one compressed byte, after a random gap
    task automatic send(input logic [7:0] b, input logic st);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        tracker.absorb_input(b, st);
        stim_items++;
    endtask

    // back-reference of length nib + 3 reaching ref_dist bytes back
    task automatic send_token(input logic [3:0] nib, input int unsigned ref_dist);
        logic [11:0] code;
        code = 12'(ref_dist - 1);
        send({nib, code[11:8]}, 1'b0);
        send(code[7:0], 1'b0);
    endtask

    // hold the input until every owed byte has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    // well-formed stream with random content, optionally cut short after some beats
    task automatic run_stream(input int unsigned size, input int unsigned token_pct,
                              input bit long_copies, input int unsigned abort_after);
        int unsigned left;
        int unsigned made;
        int unsigned items;
        int unsigned win;
        int unsigned ref_dist;
        int unsigned n;
        int          bit_pos;
        logic [7:0]  flag;
        logic [3:0]  nib;
        logic [23:0] size_bytes;
        size_bytes = 24'(size);
        send(8'($urandom_range(0, 255)), 1'b1);
        send(size_bytes[7:0], 1'b0);
        send(size_bytes[15:8], 1'b0);
        send(size_bytes[23:16], 1'b0);
        left  = size;
        made  = 0;
        items = 4;
        while (left > 0 && items < abort_after) begin
            for (bit_pos = 0; bit_pos < 8; bit_pos++) begin
                flag[bit_pos] = ($urandom_range(1, 100) <= token_pct);
            end
            send(flag, 1'b0);
            items++;
            for (bit_pos = 7; bit_pos >= 0 && left > 0 && items < abort_after; bit_pos--) begin
                if (flag[bit_pos]) begin
                    nib = long_copies ? 4'hF : 4'($urandom_range(0, 15));
                    win = (made > WINDOW_DEPTH) ? WINDOW_DEPTH : made;
                    // mostly references inside the output so far, some anywhere
                    if (made == 0 || $urandom_range(0, 9) == 0) begin
                        ref_dist = $urandom_range(1, WINDOW_DEPTH);
                    end else if (win == WINDOW_DEPTH && $urandom_range(0, 7) == 0) begin
                        ref_dist = WINDOW_DEPTH;
                    end else begin
                        ref_dist = $urandom_range(1, win);
                    end
                    send_token(nib, ref_dist);
                    items += 2;
                    n = nib + MIN_MATCH;
                    if (n > left) begin
                        n = left;
                    end
                    left -= n;
                    made += n;
                end else begin
                    send(8'($urandom_range(0, 255)), 1'b0);
                    items++;
                    left--;
                    made++;
                end
            end
        end
    endtask

    // output side: random stalls, check every beat
    initial begin
        int unsigned stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            tracker.match_output(m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
        end
    end

    // reset, stimulus and final verdict
    initial begin
        int unsigned kind;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // byte while idle is dropped
        send(8'hFF, 1'b0);
        // size 19: literal, overlapping repeat, then a maximal token that
        // reaches before the start and is cut at the end of the stream
        send(8'hFF, 1'b1);
        send(8'd19, 1'b0);
        send(8'h00, 1'b0);
        send(8'h00, 1'b0);
        send(8'b0111_0000, 1'b0);
        send(8'hFF, 1'b0);
        send_token(4'h0, 1);
        send_token(4'hF, WINDOW_DEPTH);
        // byte after the stream has finished
        send(8'hAA, 1'b0);
        // empty stream
        send(8'h10, 1'b1);
        send(8'h00, 1'b0);
        send(8'h00, 1'b0);
        send(8'h00, 1'b0);
        // stream left between the two token bytes, restarted by the next stream
        send(8'h00, 1'b1);
        send(8'h00, 1'b0);
        send(8'h01, 1'b0);
        send(8'h00, 1'b0);
        send(8'h40, 1'b0);
        send(8'h12, 1'b0);
        send(8'h20, 1'b0);
        drain();

        // random streams, some cut short, some followed by stray bytes
        while (stim_items < 90) begin
            no_idle = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 7);
            if (kind == 0) begin
                run_stream($urandom() & 32'h00FF_FFFF, 50, 1'b0, $urandom_range(1, 20));
            end else if (kind == 1) begin
                run_stream($urandom_range(0, 3), 50, 1'b0, 1000);
            end else if (kind == 2) begin
                run_stream($urandom_range(1, 40), $urandom_range(10, 90), 1'b0,
                           $urandom_range(1, 15));
            end else begin
                run_stream($urandom_range(1, 40), $urandom_range(10, 90), 1'b0, 1000);
            end
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) send(8'($urandom_range(0, 255)), 1'b0);
            end
            if ($urandom_range(0, 3) == 0) begin
                drain();
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
